/* rtl/rbte_pkg.sv */
// ----------------------------------------------------------------------------
// Ring buffer table engine package
// Shared widths, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rbte_pkg;

    // Fixed field widths of the external ports.
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Largest capacity that the capacity register can express.
    localparam int CAP_LIMIT = (1 << CNT_W) - 1;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_ENTRIES  = 16;
    localparam int DEF_ELEMENT_BITS = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = CFG_IDX_W'(1);

    // Reset values of the configuration registers.
    localparam int                    RESET_CAPACITY = 16;
    localparam logic [CFG_DATA_W-1:0] RESET_MASK     = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

endpackage

`default_nettype wire

/* rtl/rbte_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/rbte_slot_unit.sv */
// ----------------------------------------------------------------------------
// Ring buffer slot and compare unit
// Shared modular adder that maps a base slot plus an offset onto the ring,
// and the masked equality compare used by the search.
// ----------------------------------------------------------------------------
`default_nettype none

module rbte_slot_unit #(
    parameter int PW           = 4,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic [PW-1:0]                  base,
    input  wire logic [rbte_pkg::CNT_W-1:0]     offset,
    input  wire logic [rbte_pkg::CNT_W-1:0]     capacity,
    input  wire logic [ELEMENT_BITS-1:0]        entry,
    input  wire logic [ELEMENT_BITS-1:0]        criteria,
    input  wire logic [rbte_pkg::DATA_W-1:0]    mask,
    output logic      [PW-1:0]                  slot,
    output logic                                match
);

    import rbte_pkg::*;

    logic [CNT_W:0]  sum;
    logic [CNT_W:0]  cap_ext;
    logic [CNT_W:0]  wrapped;
    logic [DATA_W-1:0] entry_w;
    logic [DATA_W-1:0] crit_w;

    // The sum stays below twice the capacity, so one subtract wraps it.
    assign sum     = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
    assign cap_ext = (CNT_W+1)'(capacity);
    assign wrapped = (sum >= cap_ext) ? (sum - cap_ext) : sum;
    assign slot    = PW'(wrapped);

    // Only the low word of an element can meet the mask.
    assign entry_w = DATA_W'(entry);
    assign crit_w  = DATA_W'(criteria);
    assign match   = ((entry_w ^ crit_w) & mask) == '0;

endmodule

`default_nettype wire

/* rtl/ring_buffer_table_engine.sv */
// ----------------------------------------------------------------------------
// Ring buffer table engine
// Circular element store with add, masked find, update and remove, driven by
// a small sequencer around one shared slot and compare unit.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    opcode, item_value, logical_index
//  out      out_valid / out_ready  found, match_index, match_value, status,
//                                  fill_count
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Add and update go from acceptance through dispatch to a valid result word.
//  Find reads and compares the entries in order up to the match; remove
//  shifts each later entry down and clears the freed slot. Each entry visited
//  takes a RAM read step and a compare or write step via the shared slot unit.
//  Reset empties the buffer at once but does not clear the store itself.
//  in_ready is high only while the sequencer is idle; a result word that waits
//  on out_ready does not block acceptance of the next input word.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_table_engine #(
    parameter int MAX_ENTRIES  = rbte_pkg::DEF_MAX_ENTRIES,
    parameter int ELEMENT_BITS = rbte_pkg::DEF_ELEMENT_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [rbte_pkg::OP_W-1:0]       opcode,
    input  wire logic [rbte_pkg::DATA_W-1:0]     item_value,
    input  wire logic [rbte_pkg::IDX_W-1:0]      logical_index,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic      [rbte_pkg::IDX_W-1:0]      match_index,
    output logic      [rbte_pkg::DATA_W-1:0]     match_value,
    output logic                                 status,
    output logic      [rbte_pkg::CNT_W-1:0]      fill_count,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rbte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbte_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rbte_pkg::*;

    localparam int CAP_MAX   = (MAX_ENTRIES < CAP_LIMIT) ? MAX_ENTRIES : CAP_LIMIT;
    localparam int PW        = $clog2(CAP_MAX);
    localparam int CAP_RESET = (RESET_CAPACITY > CAP_MAX) ? CAP_MAX : RESET_CAPACITY;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_CMP,
        S_RM_RD,
        S_RM_WR,
        S_RM_CLR,
        S_DELIVER
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [ELEMENT_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [PW-1:0]           oldest_reg, oldest_next;
    logic [PW-1:0]           next_pos_reg, next_pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        cap_reg, cap_next;
    logic [DATA_W-1:0]       mask_reg, mask_next;

    logic                    res_found_reg, res_found_next;
    logic [IDX_W-1:0]        res_index_reg, res_index_next;
    logic [DATA_W-1:0]       res_value_reg, res_value_next;
    logic                    res_status_reg, res_status_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        match_index_reg, match_index_next;
    logic [DATA_W-1:0]       match_value_reg, match_value_next;
    logic                    status_reg, status_next;
    logic [CNT_W-1:0]        fill_count_reg, fill_count_next;

    logic [PW-1:0]           unit_base;
    logic [CNT_W-1:0]        unit_offset;
    logic [PW-1:0]           unit_slot;
    logic                    unit_match;

    logic                    ram_we;
    logic                    ram_re;
    logic [PW-1:0]           ram_addr;
    logic [ELEMENT_BITS-1:0] ram_wdata;
    logic [ELEMENT_BITS-1:0] ram_rdata;

    logic [CNT_W-1:0]        k_plus;
    logic [CNT_W-1:0]        idx_ext;
    logic [CNT_W-1:0]        cap_written;

    assign k_plus  = k_reg + CNT_W'(1);
    assign idx_ext = CNT_W'(idx_reg);

    always_comb
    begin
        priority if (cfg_data[CNT_W-1:0] == '0)
        begin
            cap_written = CNT_W'(1);
        end
        else if (cfg_data[CNT_W-1:0] > CNT_W'(CAP_MAX))
        begin
            cap_written = CNT_W'(CAP_MAX);
        end
        else
        begin
            cap_written = cfg_data[CNT_W-1:0];
        end
    end

    rbte_slot_unit #(
        .PW           (PW),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_slot_unit (
        .base     (unit_base),
        .offset   (unit_offset),
        .capacity (cap_reg),
        .entry    (ram_rdata),
        .criteria (val_reg),
        .mask     (mask_reg),
        .slot     (unit_slot),
        .match    (unit_match)
    );

    rbte_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CAP_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        oldest_next      = oldest_reg;
        next_pos_next    = next_pos_reg;
        count_next       = count_reg;
        cap_next         = cap_reg;
        mask_next        = mask_reg;
        res_found_next   = res_found_reg;
        res_index_next   = res_index_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        match_index_next = match_index_reg;
        match_value_next = match_value_reg;
        status_next      = status_reg;
        fill_count_next  = fill_count_reg;

        unit_base   = oldest_reg;
        unit_offset = k_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = val_reg;
        ram_addr    = unit_slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    val_next   = ELEMENT_BITS'(item_value);
                    idx_next   = logical_index;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_found_next  = 1'b0;
                res_index_next  = '0;
                res_value_next  = '0;
                res_status_next = 1'b0;
                state_next      = S_DELIVER;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        // When full the next slot is the oldest one, so both
                        // pointers move to the same wrapped position.
                        unit_base     = next_pos_reg;
                        unit_offset   = CNT_W'(1);
                        ram_addr      = next_pos_reg;
                        ram_we        = 1'b1;
                        next_pos_next = unit_slot;
                        if (count_reg >= cap_reg)
                        begin
                            oldest_next = unit_slot;
                            count_next  = cap_reg;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = S_FIND_RD;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (idx_ext >= count_reg)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            unit_offset = idx_ext;
                            ram_we      = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (idx_ext >= count_reg)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            k_next     = idx_ext;
                            state_next = ((idx_ext + CNT_W'(1)) < count_reg) ? S_RM_RD
                                                                            : S_RM_CLR;
                        end
                    end
                endcase
            end

            S_FIND_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (unit_match)
                begin
                    res_found_next = 1'b1;
                    res_index_next = IDX_W'(k_reg);
                    res_value_next = DATA_W'(ram_rdata);
                    state_next     = S_DELIVER;
                end
                else if (k_plus == count_reg)
                begin
                    state_next = S_DELIVER;
                end
                else
                begin
                    k_next     = k_plus;
                    state_next = S_FIND_RD;
                end
            end

            S_RM_RD:
            begin
                unit_offset = k_plus;
                ram_re      = 1'b1;
                state_next  = S_RM_WR;
            end

            S_RM_WR:
            begin
                // Move the later entry down one place.
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                k_next     = k_plus;
                state_next = ((k_plus + CNT_W'(1)) < count_reg) ? S_RM_RD : S_RM_CLR;
            end

            S_RM_CLR:
            begin
                // Step the write pointer back one slot and zero the freed entry.
                unit_base     = next_pos_reg;
                unit_offset   = cap_reg - CNT_W'(1);
                ram_we        = 1'b1;
                ram_wdata     = '0;
                next_pos_next = unit_slot;
                count_next    = count_reg - CNT_W'(1);
                state_next    = S_DELIVER;
            end

            S_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = res_found_reg;
                    match_index_next = res_index_reg;
                    match_value_next = res_value_reg;
                    status_next      = res_status_reg;
                    fill_count_next  = count_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The user must send configuration only while the engine is idle; the block itself does not enforce this.
        if (cfg_valid)
        begin
            if (cfg_index == REG_CAPACITY)
            begin
                cap_next      = cap_written;
                oldest_next   = '0;
                next_pos_next = '0;
                count_next    = '0;
            end
            else if (cfg_index == REG_MASK)
            begin
                mask_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_ADD;
            val_reg         <= '0;
            idx_reg         <= '0;
            k_reg           <= '0;
            oldest_reg      <= '0;
            next_pos_reg    <= '0;
            count_reg       <= '0;
            cap_reg         <= CNT_W'(CAP_RESET);
            mask_reg        <= RESET_MASK;
            res_found_reg   <= 1'b0;
            res_index_reg   <= '0;
            res_value_reg   <= '0;
            res_status_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            match_index_reg <= '0;
            match_value_reg <= '0;
            status_reg      <= 1'b0;
            fill_count_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            val_reg         <= val_next;
            idx_reg         <= idx_next;
            k_reg           <= k_next;
            oldest_reg      <= oldest_next;
            next_pos_reg    <= next_pos_next;
            count_reg       <= count_next;
            cap_reg         <= cap_next;
            mask_reg        <= mask_next;
            res_found_reg   <= res_found_next;
            res_index_reg   <= res_index_next;
            res_value_reg   <= res_value_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            match_index_reg <= match_index_next;
            match_value_reg <= match_value_next;
            status_reg      <= status_next;
            fill_count_reg  <= fill_count_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign match_value = match_value_reg;
    assign status      = status_reg;
    assign fill_count  = fill_count_reg;

    a_count_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("entry count exceeds the capacity");

    a_pointers_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(oldest_reg) < cap_reg) && (CNT_W'(next_pos_reg) < cap_reg))
        else $error("ring pointer outside the capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("engine ready again right after accepting a word");

    a_result_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DELIVER))
        else $error("result word raised outside delivery");

endmodule

`default_nettype wire

/* tb/tb_ring_buffer_table_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer table engine testbench
// Drives add, find, update and remove words through the input channel under
// a range of capacity and compare mask settings, predicts every result word
// in a scoreboard that keeps its own copy of the ring, and checks the output
// channel word by word while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ring_buffer_table_engine;
    import rbte_pkg::*;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic [DATA_W-1:0]  match_value;
        logic               status;
        logic [CNT_W-1:0]   fill_count;
    } reply_t;

    class ring_table_scoreboard;
        logic [DATA_W-1:0] slots [DEF_MAX_ENTRIES];
        int unsigned       oldest;
        int unsigned       next_free;
        int unsigned       used;
        int unsigned       cap;
        logic [DATA_W-1:0] mask;
        reply_t            replies_due[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       hits;
        int unsigned       rejected;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            oldest = 0;
            next_free = 0;
            used = 0;
            cap = RESET_CAPACITY;
            mask = RESET_MASK;
            errors = 0;
            checked = 0;
            hits = 0;
            rejected = 0;
        endfunction

        function int unsigned slot_at(int unsigned logical);
            return (oldest + logical) % cap;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned v;
            v = data[CNT_W-1:0];
            if (idx == REG_CAPACITY)
            begin
                if (v == 0)
                    cap = 1;
                else if (v > DEF_MAX_ENTRIES)
                    cap = DEF_MAX_ENTRIES;
                else
                    cap = v;
                oldest = 0;
                next_free = 0;
                used = 0;
            end
            else if (idx == REG_MASK)
            begin
                mask = data;
            end
        endfunction

        // Applies one accepted word to the ring and queues the result it must produce.
        function void note_request(op_t op, logic [DATA_W-1:0] val, logic [IDX_W-1:0] idx);
            reply_t      r;
            int unsigned i;
            int unsigned pos;
            r = '0;
            case (op)
                OP_ADD:
                begin
                    if (used >= cap)
                    begin
                        used = cap;
                        oldest = (oldest + 1) % cap;
                    end
                    else
                    begin
                        used++;
                    end
                    pos = (oldest + used - 1) % cap;
                    slots[pos] = val;
                    next_free = (pos + 1) % cap;
                end
                OP_FIND:
                begin
                    if (used == 0)
                        r.status = 1'b1;
                    else
                        for (i = 0; i < used && !r.found; i++)
                            if (((slots[slot_at(i)] ^ val) & mask) == '0)
                            begin
                                r.found = 1'b1;
                                r.match_index = IDX_W'(i);
                                r.match_value = slots[slot_at(i)];
                            end
                end
                OP_UPDATE:
                begin
                    if (idx >= used)
                        r.status = 1'b1;
                    else
                        slots[slot_at(idx)] = val;
                end
                default:
                begin
                    if (idx >= used)
                    begin
                        r.status = 1'b1;
                    end
                    else
                    begin
                        for (i = idx; i + 1 < used; i++)
                            slots[slot_at(i)] = slots[slot_at(i + 1)];
                        next_free = (next_free + cap - 1) % cap;
                        used--;
                        slots[next_free] = '0;
                    end
                end
            endcase
            r.fill_count = CNT_W'(used);
            if (r.found)
                hits++;
            if (r.status)
                rejected++;
            replies_due.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            checked++;
            if (replies_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("ERROR: result word with none expected: ");
                    $display("found=%0b index=%0d value=%h status=%0b fill=%0d",
                             got.found, got.match_index, got.match_value, got.status,
                             got.fill_count);
                end
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.found !== want.found || got.match_index !== want.match_index ||
                    got.match_value !== want.match_value || got.status !== want.status ||
                    got.fill_count !== want.fill_count)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $write("ERROR: word %0d expected found=%0b index=%0d value=%h ",
                               checked, want.found, want.match_index, want.match_value);
                        $write("status=%0b fill=%0d, ", want.status, want.fill_count);
                        $display("got found=%0b index=%0d value=%h status=%0b fill=%0d",
                                 got.found, got.match_index, got.match_value, got.status,
                                 got.fill_count);
                    end
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode = '0;
    logic [DATA_W-1:0]     item_value = '0;
    logic [IDX_W-1:0]      logical_index = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [IDX_W-1:0]      match_index;
    logic [DATA_W-1:0]     match_value;
    logic                  status;
    logic [CNT_W-1:0]      fill_count;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // While set, neither side idles.
    logic                  steady = 1'b0;
    int unsigned           stall_left = 0;
    int unsigned           settings_tried = 0;
    logic [DATA_W-1:0]     value_pool [8];
    ring_table_scoreboard  ledger;

    ring_buffer_table_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .item_value    (item_value),
        .logical_index (logical_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_index   (match_index),
        .match_value   (match_value),
        .status        (status),
        .fill_count    (fill_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Result side: check every accepted word, then choose the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                ledger.check_reply({found, match_index, match_value, status, fill_count});
            if (steady)
            begin
                out_ready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Leaves in_valid high after acceptance so that a following word needs no extra edge.
    task automatic send_word(input op_t op, input logic [DATA_W-1:0] val,
                             input logic [IDX_W-1:0] idx);
        int unsigned gap;
        if (!steady && $urandom_range(0, 99) < 6)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        item_value <= val;
        logical_index <= idx;
        do @(posedge clk); while (!in_ready);
        ledger.note_request(op, val, idx);
    endtask

    task automatic wait_drained();
        while (ledger.replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        ledger.set_register(idx, data);
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic configure(input logic set_cap, input logic [CFG_DATA_W-1:0] cap_data,
                             input logic [CFG_DATA_W-1:0] mask_data);
        wait_drained();
        put_register(REG_MASK, mask_data);
        put_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        if (set_cap)
            put_register(REG_CAPACITY, cap_data);
        cfg_valid <= 1'b0;
        settings_tried++;
    endtask

    // Values come mostly from a small pool so that finds hit and entries repeat.
    task automatic run_phase(input int unsigned count);
        op_t               op;
        logic [DATA_W-1:0] val;
        logic [IDX_W-1:0]  idx;
        int unsigned       roll;
        int unsigned       k;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (k = 2; k < 8; k++)
            value_pool[k] = $urandom;
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
                op = OP_ADD;
            else if (roll < 68)
                op = OP_FIND;
            else if (roll < 84)
                op = OP_UPDATE;
            else
                op = OP_REMOVE;
            roll = $urandom_range(0, 99);
            if (op == OP_FIND && ledger.used != 0 && roll < 40)
                val = ledger.slots[ledger.slot_at($urandom_range(0, ledger.used - 1))] ^
                      ($urandom & ~ledger.mask);
            else if (roll < 70)
                val = value_pool[$urandom_range(0, 7)];
            else
                val = $urandom;
            if (ledger.used != 0 && $urandom_range(0, 99) < 80)
                idx = IDX_W'($urandom_range(0, ledger.used - 1));
            else
                idx = IDX_W'($urandom_range(0, 15));
            send_word(op, val, idx);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        ledger = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty buffer, field extremes, misses and out of range indexes at full capacity.
        send_word(OP_FIND,   32'h0000_0000, 4'd0);
        send_word(OP_UPDATE, 32'h0000_0001, 4'd0);
        send_word(OP_REMOVE, 32'h0000_0000, 4'd15);
        send_word(OP_ADD,    32'h0000_0000, 4'd0);
        send_word(OP_ADD,    32'hFFFF_FFFF, 4'd15);
        send_word(OP_ADD,    32'h1234_5678, 4'd0);
        send_word(OP_FIND,   32'hFFFF_FFFF, 4'd0);
        send_word(OP_FIND,   32'h0000_0000, 4'd0);
        send_word(OP_FIND,   32'hDEAD_BEEF, 4'd0);
        send_word(OP_UPDATE, 32'hA5A5_A5A5, 4'd2);
        send_word(OP_UPDATE, 32'h5A5A_5A5A, 4'd3);
        send_word(OP_UPDATE, 32'h5A5A_5A5A, 4'd15);
        send_word(OP_REMOVE, 32'h0000_0000, 4'd0);
        send_word(OP_REMOVE, 32'h0000_0000, 4'd2);
        send_word(OP_FIND,   32'hA5A5_A5A5, 4'd0);
        in_valid <= 1'b0;

        // Small ring: overwrite of the oldest entry, wrap, masked find and shifting remove.
        configure(1'b1, 32'd3, 32'h0000_FFFF);
        send_word(OP_ADD,    32'h1111_0001, 4'd0);
        send_word(OP_ADD,    32'h2222_0002, 4'd0);
        send_word(OP_ADD,    32'h3333_0003, 4'd0);
        send_word(OP_ADD,    32'h4444_0004, 4'd0);
        send_word(OP_FIND,   32'h9999_0003, 4'd0);
        send_word(OP_REMOVE, 32'h0000_0000, 4'd1);
        send_word(OP_FIND,   32'hFFFF_0004, 4'd0);
        send_word(OP_UPDATE, 32'h0000_0000, 4'd1);
        send_word(OP_ADD,    32'h0000_0005, 4'd0);
        send_word(OP_REMOVE, 32'h0000_0000, 4'd2);
        in_valid <= 1'b0;

        steady <= 1'b1;
        configure(1'b1, 32'd16, 32'hFFFF_FFFF);
        run_phase(160);
        steady <= 1'b0;
        configure(1'b1, 32'd1, 32'hFFFF_FFFF);
        run_phase(100);
        configure(1'b1, 32'd0, 32'h0000_0000);
        run_phase(100);
        configure(1'b1, 32'd2, 32'h0000_FFFF);
        run_phase(120);
        configure(1'b1, 32'd31, 32'hFF00_FF00);
        run_phase(160);
        configure(1'b1, 32'h0000_0025, 32'h0000_0001);
        run_phase(130);
        configure(1'b1, 32'd17, $urandom);
        run_phase(160);
        // Mask change alone keeps the stored entries.
        configure(1'b0, 32'd0, 32'h8000_0000);
        run_phase(120);
        configure(1'b1, 32'hFFFF_FFE7, 32'hFFFF_FFFF);
        run_phase(150);
        configure(1'b1, 32'd16, $urandom);
        run_phase(200);

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Checked %0d result words across %0d register settings.",
                 ledger.checked, settings_tried);
        $display("%0d finds hit an entry, %0d requests were rejected by the engine.",
                 ledger.hits, ledger.rejected);
        if (ledger.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d result words did not match.", ledger.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Run did not complete in time.");
        $display("TEST FAILED");
        $finish;
    end

endmodule
